>>> hdl/rsps_pkg.sv
package rsps_pkg;

  typedef enum logic [1:0] {
    CMD_BASIS   = 2'd0,
    CMD_SUPPORT = 2'd1,
    CMD_ALPHA   = 2'd2,
    CMD_FEATURE = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_BIAS          = 3'd0;
  localparam logic [2:0] REG_KERNEL_SCALE  = 3'd1;
  localparam logic [2:0] REG_FEATURE_COUNT = 3'd2;
  localparam logic [2:0] REG_BASIS_COUNT   = 3'd3;
  localparam logic [2:0] REG_SUPPORT_COUNT = 3'd4;

  localparam int unsigned ACC_W = 40;

  typedef struct packed {
    cmd_t               cmd;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROJ_RD,
    ST_PROJ_MUL,
    ST_PROJ_ACC,
    ST_RND,
    ST_DIST_RD,
    ST_DIST_SQ,
    ST_DIST_ACC,
    ST_T_MUL,
    ST_EXP1,
    ST_EXP2,
    ST_ALPHA,
    ST_SCORE,
    ST_OUT
  } state_t;

  function automatic logic [16:0] exp_int(input logic [3:0] i);
    logic [16:0] r;
    begin
      case (i)
        4'd0: r = 17'd65536;  4'd1: r = 17'd24109; 4'd2: r = 17'd8869;
        4'd3: r = 17'd3263;   4'd4: r = 17'd1200;  4'd5: r = 17'd442;
        4'd6: r = 17'd162;    4'd7: r = 17'd60;    4'd8: r = 17'd22;
        4'd9: r = 17'd8;      4'd10: r = 17'd3;    4'd11: r = 17'd1;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [16:0] exp_sixteenth(input logic [3:0] i);
    logic [16:0] r;
    begin
      case (i)
        4'd0: r = 17'd65536;  4'd1: r = 17'd61565;  4'd2: r = 17'd57835;
        4'd3: r = 17'd54331;  4'd4: r = 17'd51039;  4'd5: r = 17'd47947;
        4'd6: r = 17'd45042;  4'd7: r = 17'd42313;  4'd8: r = 17'd39750;
        4'd9: r = 17'd37341;  4'd10: r = 17'd35079; 4'd11: r = 17'd32954;
        4'd12: r = 17'd30957; 4'd13: r = 17'd29081; 4'd14: r = 17'd27319;
        default: r = 17'd25664;
      endcase
      return r;
    end
  endfunction

  function automatic logic [16:0] exp_fine(input logic [3:0] i);
    logic [16:0] r;
    begin
      case (i)
        4'd0: r = 17'd65536;  4'd1: r = 17'd65280;  4'd2: r = 17'd65026;
        4'd3: r = 17'd64772;  4'd4: r = 17'd64520;  4'd5: r = 17'd64268;
        4'd6: r = 17'd64018;  4'd7: r = 17'd63768;  4'd8: r = 17'd63520;
        4'd9: r = 17'd63272;  4'd10: r = 17'd63025; 4'd11: r = 17'd62780;
        4'd12: r = 17'd62535; 4'd13: r = 17'd62291; 4'd14: r = 17'd62048;
        default: r = 17'd61806;
      endcase
      return r;
    end
  endfunction

endpackage

>>> hdl/rbf_svm_projected_scorer_core.sv
// Projected RBF-kernel SVM scorer.
// Input channel (in_valid/in_stall) carries beats of command, row_index,
// column_index and value: commands load the basis, support and alpha stores,
// or deliver one sample feature. Loads and ignored features make no result.
// The datapath dequeues any beat in its idle state; a load ends there. A
// feature beat then reads, multiplies and accumulates for each basis vector
// in use (one shared multiplier). The last feature of a sample rounds the
// projections, then runs the kernel loop: per support vector, a read, square
// and accumulate per basis element, then scale, exponent and alpha steps.
// Then a score state sets out_score and out_valid, held until taken.
// A four-entry queue sits between the accept side and the datapath, so the
// input keeps taking beats while the datapath or output is busy, until full.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write only while idle. Reset clears control and projection sums, zeroes
// bias and scale, maxes the counts; the stores hold garbage until loaded.
// A stalled result holds its value; the datapath waits at its output stage.
module rbf_svm_projected_scorer_core #(
  parameter int MAX_FEATURES = 64,
  parameter int MAX_BASIS    = 16,
  parameter int MAX_SUPPORT  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_column_index,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_score,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rsps_pkg::*;

  logic signed [31:0] bias_r;
  logic [15:0] kscale_r;
  logic [6:0]  fcount_r, scount_r;
  logic [4:0]  bcount_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r   <= '0;
      kscale_r <= '0;
      fcount_r <= 7'd64;
      bcount_r <= 5'd16;
      scount_r <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BIAS:          bias_r   <= cfg_data;
        REG_KERNEL_SCALE:  kscale_r <= cfg_data[15:0];
        REG_FEATURE_COUNT: fcount_r <= cfg_data[6:0];
        REG_BASIS_COUNT:   bcount_r <= cfg_data[4:0];
        REG_SUPPORT_COUNT: scount_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic  wr_en, full, rd_en, empty;
  item_t wr_item, rd_item;

  rsps_front #(.MAX_FEATURES(MAX_FEATURES), .MAX_BASIS(MAX_BASIS),
               .MAX_SUPPORT(MAX_SUPPORT)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_row_index,
    .in_column_index, .in_value, .feature_count(fcount_r),
    .wr_en, .wr_item, .full
  );

  rsps_queue u_queue (
    .clk, .rst_n, .wr_en, .wr_item, .full, .rd_en, .rd_item, .empty
  );

  rsps_back #(.MAX_FEATURES(MAX_FEATURES), .MAX_BASIS(MAX_BASIS),
              .MAX_SUPPORT(MAX_SUPPORT)) u_back (
    .clk, .rst_n, .rd_item, .empty, .rd_en,
    .bias(bias_r), .kernel_scale(kscale_r), .feature_count(fcount_r),
    .basis_count(bcount_r), .support_count(scount_r),
    .out_valid, .out_stall, .out_score
  );
endmodule

>>> hdl/rsps_queue.sv
module rsps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  rsps_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd_en,
  output rsps_pkg::item_t rd_item,
  output logic           empty
);
  import rsps_pkg::*;

  item_t      mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end
endmodule

>>> hdl/rsps_front.sv
module rsps_front #(
  parameter int MAX_FEATURES = 64,
  parameter int MAX_BASIS    = 16,
  parameter int MAX_SUPPORT  = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [5:0]            in_row_index,
  input  logic [5:0]            in_column_index,
  input  logic signed [15:0]    in_value,
  input  logic [6:0]            feature_count,
  output logic                  wr_en,
  output rsps_pkg::item_t       wr_item,
  input  logic                  full
);
  import rsps_pkg::*;

  logic [6:0] nf;
  logic       keep;

  always_comb begin
    if (feature_count == 7'd0) nf = 7'd1;
    else if (32'(feature_count) > MAX_FEATURES) nf = 7'(MAX_FEATURES);
    else nf = feature_count;
  end

  always_comb begin
    unique case (cmd_t'(in_command))
      CMD_BASIS:   keep = (32'(in_row_index) < MAX_BASIS) &&
                          (32'(in_column_index) < MAX_FEATURES);
      CMD_SUPPORT: keep = (32'(in_row_index) < MAX_SUPPORT) &&
                          (32'(in_column_index) < MAX_BASIS);
      CMD_ALPHA:   keep = (32'(in_row_index) < MAX_SUPPORT);
      default:     keep = ({1'b0, in_column_index} < nf);
    endcase
  end

  assign in_stall      = full;
  assign wr_en         = in_valid && !full && keep;
  assign wr_item.cmd   = cmd_t'(in_command);
  assign wr_item.row   = in_row_index;
  assign wr_item.col   = in_column_index;
  assign wr_item.value = in_value;

  logic unused_clk;
  assign unused_clk = clk ^ rst_n;
endmodule

>>> hdl/rsps_back.sv
module rsps_back #(
  parameter int MAX_FEATURES = 64,
  parameter int MAX_BASIS    = 16,
  parameter int MAX_SUPPORT  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rsps_pkg::item_t    rd_item,
  input  logic               empty,
  output logic               rd_en,
  input  logic signed [31:0] bias,
  input  logic [15:0]        kernel_scale,
  input  logic [6:0]         feature_count,
  input  logic [4:0]         basis_count,
  input  logic [6:0]         support_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_score
);
  import rsps_pkg::*;

  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int BW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int SW = (MAX_SUPPORT > 1) ? $clog2(MAX_SUPPORT) : 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [15:0] basis_mem   [MAX_BASIS*MAX_FEATURES];
  logic signed [15:0] support_mem [MAX_SUPPORT*MAX_BASIS];
  logic signed [15:0] alpha_mem   [MAX_SUPPORT];
  logic signed [ACC_W-1:0] proj_r [MAX_BASIS];
  logic signed [15:0] rnd_r [MAX_BASIS];

  state_t state_r, state_nxt;
  item_t  cur_r;
  logic [BW:0] j_r;
  logic [SW:0] i_r;
  logic signed [15:0] bas_q_r, sv_q_r, al_q_r;
  logic signed [31:0] prod_r;
  logic signed [16:0] diff_r;
  logic [39:0] dist_r;
  logic [55:0] t_r;
  logic [16:0] e1_r, e2_r;
  logic signed [47:0] acc_r;
  logic signed [31:0] score_r;
  logic out_valid_r;

  logic [BW:0] nb;
  logic [SW:0] nv;
  logic [6:0]  nf;
  logic        last_b, last_v;

  always_comb begin
    if (basis_count == 5'd0) nb = (BW+1)'(1);
    else if (32'(basis_count) > MAX_BASIS) nb = (BW+1)'(MAX_BASIS);
    else nb = (BW+1)'(basis_count);
    if (support_count == 7'd0) nv = (SW+1)'(1);
    else if (32'(support_count) > MAX_SUPPORT) nv = (SW+1)'(MAX_SUPPORT);
    else nv = (SW+1)'(support_count);
    if (feature_count == 7'd0) nf = 7'd1;
    else if (32'(feature_count) > MAX_FEATURES) nf = 7'(MAX_FEATURES);
    else nf = feature_count;
  end

  assign last_b = (j_r + 1'b1 == nb);
  assign last_v = (i_r + 1'b1 == nv);
  assign out_valid = out_valid_r;
  assign out_score = score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    rd_en = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          rd_en = 1'b1;
          if (rd_item.cmd == CMD_FEATURE) state_nxt = ST_PROJ_RD;
        end
      end
      ST_PROJ_RD:  state_nxt = ST_PROJ_MUL;
      ST_PROJ_MUL: state_nxt = ST_PROJ_ACC;
      ST_PROJ_ACC: begin
        if (!last_b) state_nxt = ST_PROJ_RD;
        else if ({1'b0, cur_r.col} == nf - 7'd1) state_nxt = ST_RND;
        else state_nxt = ST_IDLE;
      end
      ST_RND:      state_nxt = last_b ? ST_DIST_RD : ST_RND;
      ST_DIST_RD:  state_nxt = ST_DIST_SQ;
      ST_DIST_SQ:  state_nxt = ST_DIST_ACC;
      ST_DIST_ACC: state_nxt = last_b ? ST_T_MUL : ST_DIST_RD;
      ST_T_MUL:    state_nxt = ST_EXP1;
      ST_EXP1:     state_nxt = ST_EXP2;
      ST_EXP2:     state_nxt = ST_ALPHA;
      ST_ALPHA:    state_nxt = last_v ? ST_SCORE : ST_DIST_RD;
      ST_SCORE:    state_nxt = ST_OUT;
      ST_OUT:      if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && !empty) begin
      unique case (rd_item.cmd)
        CMD_BASIS: basis_mem[rd_item.row[BW-1:0]*MAX_FEATURES +
                             32'(rd_item.col)] <= rd_item.value;
        CMD_SUPPORT: support_mem[32'(rd_item.row)*MAX_BASIS +
                                 32'(rd_item.col)] <= rd_item.value;
        CMD_ALPHA: alpha_mem[rd_item.row[SW-1:0]] <= rd_item.value;
        default: ;
      endcase
    end
    bas_q_r <= basis_mem[32'(j_r[BW-1:0])*MAX_FEATURES + 32'(cur_r.col)];
    sv_q_r  <= support_mem[32'(i_r[SW-1:0])*MAX_BASIS + 32'(j_r[BW-1:0])];
    al_q_r  <= alpha_mem[i_r[SW-1:0]];
  end

  logic signed [ACC_W:0] psum;
  logic signed [ACC_W:0] prnd;
  logic signed [15:0] psat;
  logic [39:0] t_idx;
  logic [33:0] e1_p, e2_p;

  always_comb begin
    psum = {proj_r[j_r[BW-1:0]][ACC_W-1], proj_r[j_r[BW-1:0]]} +
           (ACC_W+1)'(prod_r);
    prnd = $signed({proj_r[j_r[BW-1:0]][ACC_W-1], proj_r[j_r[BW-1:0]]}) +
           41'sd8192;
    if ((prnd >>> 14) > 41'sd32767) psat = 16'sd32767;
    else if ((prnd >>> 14) < -41'sd32768) psat = -16'sd32768;
    else psat = prnd[29:14];
    t_idx = t_r[55:16];
    e1_p = 34'(exp_int(t_r[35:32])) * 34'(exp_sixteenth(t_r[31:28])) + 34'd32768;
    e2_p = 34'(e1_r) * 34'(exp_fine(t_r[27:24])) + 34'd32768;
  end

  logic signed [48:0] srnd;
  logic signed [33:0] ssum;
  always_comb begin
    srnd = {acc_r[47], acc_r} + 49'sd128;
    ssum = 34'(srnd >>> 8) + 34'(bias);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_BASIS; k++) proj_r[k] <= '0;
      out_valid_r <= 1'b0;
      j_r <= '0;
      i_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          cur_r <= rd_item;
          j_r <= '0;
          i_r <= '0;
          if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
        end
        ST_PROJ_MUL: prod_r <= cur_r.value * bas_q_r;
        ST_PROJ_ACC: begin
          if (psum[ACC_W] != psum[ACC_W-1])
            proj_r[j_r[BW-1:0]] <= psum[ACC_W] ? ACC_MIN : ACC_MAX;
          else proj_r[j_r[BW-1:0]] <= psum[ACC_W-1:0];
          j_r <= last_b ? '0 : j_r + 1'b1;
        end
        ST_RND: begin
          rnd_r[j_r[BW-1:0]] <= psat;
          proj_r[j_r[BW-1:0]] <= '0;
          j_r <= last_b ? '0 : j_r + 1'b1;
          acc_r <= '0;
          dist_r <= '0;
        end
        ST_DIST_SQ: begin
          diff_r <= 17'(rnd_r[j_r[BW-1:0]]) - 17'(sv_q_r);
        end
        ST_DIST_ACC: begin
          dist_r <= dist_r + 40'($unsigned(34'(diff_r) * 34'(diff_r)));
          j_r <= last_b ? '0 : j_r + 1'b1;
        end
        ST_T_MUL: t_r <= dist_r * 56'(kernel_scale);
        ST_EXP1: e1_r <= e1_p[32:16];
        ST_EXP2: e2_r <= (t_idx != 40'd0 && t_r[55:36] != 20'd0) ? 17'd0 :
                         (e2_p[32:16] > 17'd65535 ? 17'd65535 : e2_p[32:16]);
        ST_ALPHA: begin
          acc_r <= acc_r + 48'(al_q_r * $signed({1'b0, e2_r[15:0]}));
          dist_r <= '0;
          i_r <= i_r + 1'b1;
        end
        ST_SCORE: begin
          if (ssum > 34'sd2147483647) score_r <= 32'h7fffffff;
          else if (ssum < -34'sd2147483648) score_r <= 32'h80000000;
          else score_r <= ssum[31:0];
          out_valid_r <= 1'b1;
        end
        ST_OUT: begin
          if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  logic unused_bits;
  assign unused_bits = ^{diff_r[16]} ^ ^{e1_p[33], e1_p[15:0], e2_p[33],
                       e2_p[15:0]};
endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import rsps_pkg::*;

  localparam int SETTLE_CYCLES = 600;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;
  localparam longint unsigned EXP_I[16] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                            22, 8, 3, 1, 0, 0, 0, 0};
  localparam longint unsigned EXP_S[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                            45042, 42313, 39750, 37341, 35079, 32954,
                                            30957, 29081, 27319, 25664};
  localparam longint unsigned EXP_F[16] = '{65536, 65280, 65026, 64772, 64520, 64268,
                                            64018, 63768, 63520, 63272, 63025, 62780,
                                            62535, 62291, 62048, 61806};

  typedef struct {
    cmd_t               cmd;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] val;
    bit                 typed;
    logic signed [31:0] score;
  } drow_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_command;
  logic [5:0] in_row_index, in_column_index;
  logic signed [15:0] in_value;
  logic out_valid, out_stall;
  logic signed [31:0] out_score;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  logic in_stall_s, out_valid_s, cfg_ready_s;
  logic signed [31:0] out_score_s;

  bit idle_en = 1'b1;
  int fails = 0;
  int n_items = 0;
  int n_scores = 0;
  logic signed [31:0] score_q[$];

  int signed bias_r;
  longint unsigned kscale_r;
  int fcnt_r, bcnt_r, scnt_r;
  logic signed [15:0] basis_m[1024];
  logic signed [15:0] sv_m[1024];
  logic signed [15:0] alpha_m[64];
  longint proj_sum[16];

  drow_t dtab[14] = '{
    '{CMD_BASIS,   6'd0,  6'd0,  16'sd16384,  1'b0, 32'sd0},
    '{CMD_BASIS,   6'd0,  6'd1,  -16'sd32768, 1'b0, 32'sd0},
    '{CMD_SUPPORT, 6'd0,  6'd0,  16'sd32767,  1'b0, 32'sd0},
    '{CMD_ALPHA,   6'd0,  6'd0,  16'sd32767,  1'b0, 32'sd0},
    '{CMD_FEATURE, 6'd0,  6'd1,  16'sd0,      1'b1, 32'sh7FFFFFFF},
    '{CMD_FEATURE, 6'd0,  6'd0,  16'sd32767,  1'b0, 32'sd0},
    '{CMD_FEATURE, 6'd0,  6'd5,  16'sd100,    1'b0, 32'sd0},
    '{CMD_FEATURE, 6'd0,  6'd1,  16'sd0,      1'b1, 32'sh7FFFFFFF},
    '{CMD_ALPHA,   6'd0,  6'd63, -16'sd32768, 1'b0, 32'sd0},
    '{CMD_FEATURE, 6'd63, 6'd0,  -16'sd32768, 1'b0, 32'sd0},
    '{CMD_FEATURE, 6'd0,  6'd1,  -16'sd32768, 1'b0, 32'sd0},
    '{CMD_BASIS,   6'd16, 6'd0,  16'sd1,      1'b0, 32'sd0},
    '{CMD_SUPPORT, 6'd0,  6'd16, 16'sd1,      1'b0, 32'sd0},
    '{CMD_BASIS,   6'd15, 6'd63, -16'sd1,     1'b0, 32'sd0}
  };

  rbf_svm_projected_scorer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_row_index(in_row_index),
    .in_column_index(in_column_index), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_score(out_score),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

  always @(negedge clk) begin
    in_stall_s = in_stall;
    out_valid_s = out_valid;
    out_score_s = out_score;
    cfg_ready_s = cfg_ready;
  end

  function automatic int clamp_count(int c, int m);
    return (c == 0) ? 1 : ((c > m) ? m : c);
  endfunction

  function automatic longint unsigned neg_exp(longint unsigned t);
    longint unsigned r;
    if (t >= (64'd16 << 32)) return 0;
    r = (EXP_I[t[35:32]] * EXP_S[t[31:28]] + 32768) >> 16;
    r = (r * EXP_F[t[27:24]] + 32768) >> 16;
    return (r > 65535) ? 65535 : r;
  endfunction

  function automatic longint kernel_score();
    int nb, nv;
    longint p, d, acc, s, e;
    longint unsigned dsq;
    longint pr[16];
    nb = clamp_count(bcnt_r, 16);
    nv = clamp_count(scnt_r, 64);
    acc = 0;
    for (int j = 0; j < nb; j++) begin
      p = (proj_sum[j] + 8192) >>> 14;
      pr[j] = (p > 32767) ? 32767 : ((p < -32768) ? -32768 : p);
    end
    for (int i = 0; i < nv; i++) begin
      dsq = 0;
      for (int j = 0; j < nb; j++) begin
        d = pr[j] - longint'(sv_m[i * 16 + j]);
        dsq += longint'(d * d);
      end
      e = longint'(neg_exp(dsq * kscale_r));
      acc += longint'(alpha_m[i]) * e;
    end
    s = ((acc + 128) >>> 8) + longint'(bias_r);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic bit score_step(cmd_t c, logic [5:0] r, logic [5:0] col,
                                    logic signed [15:0] v, output logic signed [31:0] sc);
    int nf, nb;
    longint s;
    sc = '0;
    case (c)
      CMD_BASIS: if (r < 16) basis_m[r * 64 + col] = v;
      CMD_SUPPORT: if (col < 16) sv_m[r * 16 + col] = v;
      CMD_ALPHA: alpha_m[r] = v;
      CMD_FEATURE: begin
        nf = clamp_count(fcnt_r, 64);
        nb = clamp_count(bcnt_r, 16);
        if (col >= nf) return 1'b0;
        for (int j = 0; j < nb; j++) begin
          s = proj_sum[j] + longint'(v) * longint'(basis_m[j * 64 + col]);
          proj_sum[j] = (s > ACC_HI) ? ACC_HI : ((s < ACC_LO) ? ACC_LO : s);
        end
        if (col == nf - 1) begin
          sc = 32'(kernel_score());
          for (int j = 0; j < 16; j++) proj_sum[j] = 0;
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic send_beat(cmd_t c, logic [5:0] r, logic [5:0] col, logic signed [15:0] v,
                           bit typed = 1'b0, logic signed [31:0] tscore = '0);
    logic signed [31:0] sc;
    if (idle_en && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_row_index <= r;
    in_column_index <= col;
    in_value <= v;
    @(posedge clk);
    while (in_stall_s) @(posedge clk);
    n_items++;
    if (score_step(c, r, col, v, sc)) begin
      score_q.push_back(typed ? tscore : sc);
      n_scores++;
    end
  endtask

  task automatic write_regs(int signed b, int ks, int fc, int bc, int sc, bit stray = 1'b0);
    logic [31:0] vals[5];
    vals = '{32'(b), 32'(ks), 32'(fc), 32'(bc), 32'(sc)};
    for (int i = 0; i < 6; i++) begin
      if (i == 5 && !stray) break;
      cfg_valid <= 1'b1;
      cfg_index <= (i == 5) ? REG_SUPPORT_COUNT + 3'd1 : 3'(i);
      cfg_data <= (i == 5) ? 32'hFFFF_FFFF : vals[i];
      @(posedge clk);
      while (!cfg_ready_s) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    bias_r = b;
    kscale_r = ks & 16'hFFFF;
    fcnt_r = fc & 7'h7F;
    bcnt_r = bc & 5'h1F;
    scnt_r = sc & 7'h7F;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_s && !out_stall) begin
        if (score_q.size() == 0) begin
          $error("score: no result expected, actual %0d", out_score_s);
          fails++;
        end else begin
          if (out_score_s !== score_q[0]) begin
            $error("score: expected %0d actual %0d", score_q[0], out_score_s);
            fails++;
          end
          void'(score_q.pop_front());
        end
      end
      out_stall <= idle_en && ($urandom_range(99) < 38);
    end
  end

  initial begin
    int nf, nb, nv, mode, ph_items, ks;
    int signed b;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_BASIS;
    in_row_index <= '0;
    in_column_index <= '0;
    in_value <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BIAS;
    cfg_data <= '0;
    bias_r = 0; kscale_r = 0; fcnt_r = 64; bcnt_r = 16; scnt_r = 64;
    for (int j = 0; j < 16; j++) proj_sum[j] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int c = 0; c < 64; c++) send_beat(CMD_BASIS, 6'd0, 6'(c), 16'($urandom));
    for (int r = 1; r < 16; r++) begin
      for (int c = 0; c < 8; c++) send_beat(CMD_BASIS, 6'(r), 6'(c), 16'($urandom));
      send_beat(CMD_BASIS, 6'(r), 6'd63, 16'($urandom));
    end
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 16; c++) send_beat(CMD_SUPPORT, 6'(r), 6'(c), 16'($urandom));
    for (int r = 8; r < 64; r++) send_beat(CMD_SUPPORT, 6'(r), 6'd0, 16'($urandom));
    for (int r = 0; r < 64; r++) send_beat(CMD_ALPHA, 6'(r), 6'($urandom), 16'($urandom));
    settle();

    write_regs(32'sh7FFFFFFF, 65535, 2, 1, 1, 1'b1);
    foreach (dtab[i])
      send_beat(dtab[i].cmd, dtab[i].row, dtab[i].col, dtab[i].val, dtab[i].typed, dtab[i].score);
    settle();

    write_regs(-32'sh7FFFFFFF - 1, 0, 64, 16, 1);
    for (int j = 0; j < 16; j++) send_beat(CMD_BASIS, 6'(j), 6'd0, -16'sd32768);
    idle_en = 1'b0;
    for (int k = 0; k < 520; k++) send_beat(CMD_FEATURE, 6'($urandom), 6'd0, -16'sd32768);
    send_beat(CMD_FEATURE, 6'd0, 6'd63, 16'($urandom));
    idle_en = 1'b1;
    settle();

    for (int ph = 0; ph < 4 || n_items < 1200 || n_scores < 40; ph++) begin
      settle();
      mode = (ph < 2) ? ph : ((ph == 2) ? 4 : $urandom_range(2, 11));
      b = (mode == 2) ? 32'sh7FFFFFFF : ((mode == 3) ? -32'sh7FFFFFFF - 1 : int'($urandom));
      ks = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 63);
      if (mode == 0) write_regs(b, 65535, 8, 16, 8);
      else if (mode == 1) write_regs(b, 0, 0, 31, 0);
      else if (mode == 4) write_regs(b, ks, $urandom_range(65, 127), 0, $urandom_range(65, 127));
      else write_regs(b, ks, $urandom_range(1, 8), $urandom_range(0, 4), $urandom_range(0, 8));
      idle_en = (ph != 3);
      nf = clamp_count(fcnt_r, 64);
      nb = clamp_count(bcnt_r, 16);
      nv = clamp_count(scnt_r, 64);
      ph_items = 0;
      while (ph_items < 60) begin
        if ($urandom_range(99) < 85) begin
          for (int c = 0; c < nf; c++)
            send_beat(CMD_FEATURE, 6'($urandom), 6'(c), 16'($urandom));
          ph_items += nf;
        end else begin
          send_beat(cmd_t'($urandom_range(3)), 6'($urandom), 6'($urandom), 16'($urandom));
          ph_items++;
        end
      end
      idle_en = 1'b1;
    end

    settle();
    if (score_q.size() != 0) fails++;
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rsps_pkg.sv
hdl/rsps_queue.sv
hdl/rsps_front.sv
hdl/rsps_back.sv
hdl/rbf_svm_projected_scorer_core.sv
verif/tb.sv
